// ----- src/pre_pkg.sv -----
package pre_pkg;

    localparam int WIDTH_BITS = 31;
    localparam int HW_BITS    = 30;
    localparam int VERT_COUNT = 12;
    localparam int VIDX_BITS  = 4;

    localparam logic [1:0] CORNER_LS = 2'd0;
    localparam logic [1:0] CORNER_RS = 2'd1;
    localparam logic [1:0] CORNER_LE = 2'd2;
    localparam logic [1:0] CORNER_RE = 2'd3;

    localparam logic [1:0] CORNER_ORDER [VERT_COUNT] = '{
        CORNER_LS, CORNER_RS, CORNER_LE, CORNER_RS, CORNER_RE, CORNER_LE,
        CORNER_LE, CORNER_RS, CORNER_LS, CORNER_LE, CORNER_RE, CORNER_RS
    };

    typedef struct packed {
        logic                 load;
        logic                 mul_step;
        logic                 sqrt_init;
        logic                 sqrt_step;
        logic                 div_init;
        logic                 div_step;
        logic                 emit;
        logic                 commit;
        logic [VIDX_BITS-1:0] vert_idx;
    } cmd_t;

    typedef struct packed {
        logic run;
        logic len_ok;
        logic out_free;
    } status_t;

endpackage

// ----- src/polyline_ribbon_extruder.sv -----
// No segment (line start, no previous point, zero width): point is loaded, checked and committed.
// Segment: load, check, max(COORD_BITS+1, 30) multiply steps, sum, COORD_BITS+2 square root steps,
//   length check, 30 divide steps, 12 vertices at one per cycle when m_tready allows, commit.
// The bit-serial square root and the two 30-step dividers set the segment time.
// One point is taken at a time; the next is accepted while the last vertex waits on m_tready.
// Reset (aresetn low, synchronous) clears the width to 0 and forgets the previous point.
module polyline_ribbon_extruder #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // point_x, point_y, point_z
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]       s_tdata,
    // line_start
    input  logic                                    s_tuser,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [pre_pkg::WIDTH_BITS-1:0]          cfg_data,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // vertex_x, vertex_y, vertex_z
    output logic [((3*COORD_BITS+7)/8)*8-1:0]       m_tdata,
    // corner_id
    output logic [1:0]                              m_tuser,
    output logic                                    m_tlast
);
    import pre_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int DW = ((3 * C + 7) / 8) * 8;

    cmd_t          cmd;
    status_t       status;
    logic [C-1:0]  vx, vy, vz;

    assign cfg_ready = 1'b1;

    pre_ctrl #(
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pre_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_x       (s_tdata[C-1:0]),
        .in_y       (s_tdata[2*C-1:C]),
        .in_z       (s_tdata[3*C-1:2*C]),
        .in_start   (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_x      (vx),
        .out_y      (vy),
        .out_z      (vz),
        .out_corner (m_tuser),
        .out_last   (m_tlast)
    );

    assign m_tdata = DW'({vz, vy, vx});

endmodule

// ----- src/pre_ctrl.sv -----
module pre_ctrl #(
    parameter int COORD_BITS = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  pre_pkg::status_t status,
    output pre_pkg::cmd_t    cmd
);
    import pre_pkg::*;

    localparam int AW      = COORD_BITS + 1;
    localparam int SQ      = COORD_BITS + 2;
    localparam int MC      = (AW > HW_BITS) ? AW : HW_BITS;
    localparam int CNT_MAX = (SQ > VERT_COUNT) ? SQ : VERT_COUNT;
    localparam int CW      = $clog2(CNT_MAX + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CHECK  = 4'd1;
    localparam logic [3:0] ST_MUL    = 4'd2;
    localparam logic [3:0] ST_SUM    = 4'd3;
    localparam logic [3:0] ST_SQRT   = 4'd4;
    localparam logic [3:0] ST_LEN    = 4'd5;
    localparam logic [3:0] ST_DIV    = 4'd6;
    localparam logic [3:0] ST_EMIT   = 4'd7;
    localparam logic [3:0] ST_COMMIT = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.vert_idx = cnt_reg[VIDX_BITS-1:0];
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cnt_next   = '0;
                state_next = status.run ? ST_MUL : ST_COMMIT;
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CW'(MC - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                cmd.sqrt_init = 1'b1;
                state_next    = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CW'(SQ - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_LEN;
                end
            end
            ST_LEN: begin
                cmd.div_init = 1'b1;
                state_next   = status.len_ok ? ST_DIV : ST_COMMIT;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CW'(HW_BITS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CW'(VERT_COUNT - 1)) begin
                        cnt_next   = '0;
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("vertex issued into a full output register");

    a_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.mul_step, cmd.sqrt_step, cmd.div_step, cmd.emit, cmd.load}))
        else $error("more than one datapath step in a cycle");

    a_commit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> s_tready)
        else $error("commit not followed by idle");

    a_load_check: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_CHECK) && !s_tready)
        else $error("accepted word not followed by check");

endmodule

// ----- src/pre_dp.sv -----
module pre_dp #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [COORD_BITS-1:0]               in_x,
    input  logic [COORD_BITS-1:0]               in_y,
    input  logic [COORD_BITS-1:0]               in_z,
    input  logic                                in_start,
    input  logic                                cfg_valid,
    input  logic [pre_pkg::WIDTH_BITS-1:0]      cfg_data,
    input  pre_pkg::cmd_t                       cmd,
    output pre_pkg::status_t                    status,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [COORD_BITS-1:0]               out_x,
    output logic [COORD_BITS-1:0]               out_y,
    output logic [COORD_BITS-1:0]               out_z,
    output logic [1:0]                          out_corner,
    output logic                                out_last
);
    import pre_pkg::*;

    localparam int C       = COORD_BITS;
    localparam int AW      = C + 1;
    localparam int SQW     = 2 * AW;
    localparam int SQ      = C + 2;
    localparam int RW      = 2 * SQ;
    localparam int PW      = AW + HW_BITS;
    localparam int LW      = C + 1;
    localparam int SW      = ((C > WIDTH_BITS) ? C : WIDTH_BITS) + 2;
    localparam int MIN_LEN = ((2 ** FRAC_BITS) + 9999) / 10000;

    logic [WIDTH_BITS-1:0] width_reg;
    logic                  have_prev_reg;
    logic                  run_reg;
    logic signed [C-1:0]   prev_x_reg, prev_y_reg, prev_z_reg;
    logic signed [C-1:0]   cur_x_reg, cur_y_reg, cur_z_reg;
    logic                  dx_neg_reg, dz_neg_reg;

    logic [SQW-1:0]        sqx_acc_reg, sqx_mc_reg, sqz_acc_reg, sqz_mc_reg;
    logic [AW-1:0]         sqx_mp_reg, sqz_mp_reg;
    logic [PW-1:0]         hwx_acc_reg, hwx_mc_reg, hwz_acc_reg, hwz_mc_reg;
    logic [HW_BITS-1:0]    hwx_mp_reg, hwz_mp_reg;

    logic [RW-1:0]         rad_reg;
    logic [SQ+1:0]         srem_reg;
    logic [SQ-1:0]         root_reg;

    logic [LW-1:0]         drx_rem_reg, drz_rem_reg;
    logic [HW_BITS-1:0]    drx_lo_reg, drz_lo_reg, qx_reg, qz_reg;

    logic                  ov_reg;
    logic [C-1:0]          ox_reg, oy_reg, oz_reg;
    logic [1:0]            oc_reg;
    logic                  ol_reg;

    logic signed [AW-1:0]  dx, dz;
    logic [AW-1:0]         adx, adz;
    logic [HW_BITS-1:0]    hw;
    logic [SQ+1:0]         srem_sh, strial;
    logic                  sge;
    logic [LW:0]           tx, tz;
    logic                  gx, gz;
    logic [LW-1:0]         len;
    logic signed [SW-1:0]  nx, nz, bx, bz, vx, vz, vmax, vmin;
    logic [1:0]            corner;
    logic [C-1:0]          sat_x, sat_z, vy;

    assign hw  = width_reg[WIDTH_BITS-1:1];
    assign dx  = AW'(signed'(in_x)) - AW'(signed'(prev_x_reg));
    assign dz  = AW'(signed'(in_z)) - AW'(signed'(prev_z_reg));
    assign adx = dx[AW-1] ? AW'(-dx) : AW'(dx);
    assign adz = dz[AW-1] ? AW'(-dz) : AW'(dz);

    assign srem_sh = {srem_reg[SQ-1:0], rad_reg[RW-1:RW-2]};
    assign strial  = {root_reg, 2'b01};
    assign sge     = (srem_sh >= strial);

    assign len = root_reg[LW-1:0];
    assign tx  = {drx_rem_reg, drx_lo_reg[HW_BITS-1]};
    assign tz  = {drz_rem_reg, drz_lo_reg[HW_BITS-1]};
    assign gx  = (tx >= {1'b0, len});
    assign gz  = (tz >= {1'b0, len});

    assign nx = dz_neg_reg ? SW'(signed'({1'b0, qz_reg})) : -SW'(signed'({1'b0, qz_reg}));
    assign nz = dx_neg_reg ? -SW'(signed'({1'b0, qx_reg})) : SW'(signed'({1'b0, qx_reg}));

    assign corner = CORNER_ORDER[cmd.vert_idx];
    assign bx     = corner[1] ? SW'(cur_x_reg) : SW'(prev_x_reg);
    assign bz     = corner[1] ? SW'(cur_z_reg) : SW'(prev_z_reg);
    assign vy     = corner[1] ? cur_y_reg : prev_y_reg;
    assign vx     = corner[0] ? bx - nx : bx + nx;
    assign vz     = corner[0] ? bz - nz : bz + nz;
    assign vmax   = SW'((64'sd1 <<< (C - 1)) - 64'sd1);
    assign vmin   = -vmax - SW'(1);
    assign sat_x  = (vx > vmax) ? C'(vmax) : ((vx < vmin) ? C'(vmin) : C'(vx));
    assign sat_z  = (vz > vmax) ? C'(vmax) : ((vz < vmin) ? C'(vmin) : C'(vz));

    assign status.run      = run_reg;
    assign status.len_ok   = (root_reg >= SQ'(MIN_LEN));
    assign status.out_free = !ov_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= '0;
            have_prev_reg <= 1'b0;
            run_reg       <= 1'b0;
            ov_reg        <= 1'b0;
        end else begin
            if (cfg_valid) begin
                width_reg <= cfg_data;
            end
            if (cmd.load) begin
                run_reg <= !in_start && have_prev_reg && (width_reg != '0);
            end
            if (cmd.commit) begin
                have_prev_reg <= 1'b1;
            end
            if (cmd.emit) begin
                ov_reg <= 1'b1;
            end else if (out_ready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_x_reg   <= in_x;
            cur_y_reg   <= in_y;
            cur_z_reg   <= in_z;
            dx_neg_reg  <= dx[AW-1];
            dz_neg_reg  <= dz[AW-1];
            sqx_acc_reg <= '0;
            sqz_acc_reg <= '0;
            hwx_acc_reg <= '0;
            hwz_acc_reg <= '0;
            sqx_mc_reg  <= SQW'(adx);
            sqz_mc_reg  <= SQW'(adz);
            sqx_mp_reg  <= adx;
            sqz_mp_reg  <= adz;
            hwx_mc_reg  <= PW'(adx);
            hwz_mc_reg  <= PW'(adz);
            hwx_mp_reg  <= hw;
            hwz_mp_reg  <= hw;
        end
        if (cmd.mul_step) begin
            if (sqx_mp_reg[0]) sqx_acc_reg <= sqx_acc_reg + sqx_mc_reg;
            if (sqz_mp_reg[0]) sqz_acc_reg <= sqz_acc_reg + sqz_mc_reg;
            if (hwx_mp_reg[0]) hwx_acc_reg <= hwx_acc_reg + hwx_mc_reg;
            if (hwz_mp_reg[0]) hwz_acc_reg <= hwz_acc_reg + hwz_mc_reg;
            sqx_mc_reg <= sqx_mc_reg << 1;
            sqz_mc_reg <= sqz_mc_reg << 1;
            hwx_mc_reg <= hwx_mc_reg << 1;
            hwz_mc_reg <= hwz_mc_reg << 1;
            sqx_mp_reg <= sqx_mp_reg >> 1;
            sqz_mp_reg <= sqz_mp_reg >> 1;
            hwx_mp_reg <= hwx_mp_reg >> 1;
            hwz_mp_reg <= hwz_mp_reg >> 1;
        end
        if (cmd.sqrt_init) begin
            rad_reg  <= RW'(sqx_acc_reg) + RW'(sqz_acc_reg);
            srem_reg <= '0;
            root_reg <= '0;
        end
        if (cmd.sqrt_step) begin
            rad_reg  <= rad_reg << 2;
            srem_reg <= sge ? (srem_sh - strial) : srem_sh;
            root_reg <= {root_reg[SQ-2:0], sge};
        end
        if (cmd.div_init) begin
            drx_rem_reg <= hwx_acc_reg[PW-1:HW_BITS];
            drz_rem_reg <= hwz_acc_reg[PW-1:HW_BITS];
            drx_lo_reg  <= hwx_acc_reg[HW_BITS-1:0];
            drz_lo_reg  <= hwz_acc_reg[HW_BITS-1:0];
            qx_reg      <= '0;
            qz_reg      <= '0;
        end
        if (cmd.div_step) begin
            drx_rem_reg <= gx ? LW'(tx - {1'b0, len}) : tx[LW-1:0];
            drz_rem_reg <= gz ? LW'(tz - {1'b0, len}) : tz[LW-1:0];
            drx_lo_reg  <= drx_lo_reg << 1;
            drz_lo_reg  <= drz_lo_reg << 1;
            qx_reg      <= {qx_reg[HW_BITS-2:0], gx};
            qz_reg      <= {qz_reg[HW_BITS-2:0], gz};
        end
        if (cmd.emit) begin
            ox_reg <= sat_x;
            oy_reg <= vy;
            oz_reg <= sat_z;
            oc_reg <= corner;
            ol_reg <= (cmd.vert_idx == VIDX_BITS'(VERT_COUNT - 1));
        end
        if (cmd.commit) begin
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
            prev_z_reg <= cur_z_reg;
        end
    end

    assign out_valid  = ov_reg;
    assign out_x      = ox_reg;
    assign out_y      = oy_reg;
    assign out_z      = oz_reg;
    assign out_corner = oc_reg;
    assign out_last   = ol_reg;

    a_emit_after_len: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> run_reg && status.len_ok)
        else $error("vertex issued for a skipped segment");

    a_commit_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> have_prev_reg)
        else $error("previous point not marked after commit");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> ov_reg)
        else $error("output register not loaded");

endmodule
